// ----- hw/rtl/shll_pkg.sv -----
// Shared types and constants for the sliding-window HyperLogLog sketch.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package shll_pkg;

   // Fixed field widths
   localparam int HASH_BITS      = 32;
   localparam int MODE_W         = 2;
   localparam int TIME_W         = 63;
   localparam int WIN_W          = 32;
   localparam int SUM_W          = 34;
   localparam int EMPTY_W        = 11;
   // Rank needs 5 bits: 23 ranks at the default index width
   localparam int RANK_W         = 5;
   // window_seconds * 10^6 fits in 52 bits
   localparam int SPAN_W         = 52;
   localparam int USEC_W         = 20;
   localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

   // Default number of register index bits
   localparam int INDEX_BITS_DEF = 10;

   // Request operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_ADD      = 2'd0,
      MODE_ESTIMATE = 2'd1,
      MODE_CLEAR    = 2'd2
   } mode_type;

   // Controller to datapath commands
   typedef struct packed {
      logic add_ld;    // capture an add request
      logic est_ld;    // capture estimate operands, clear accumulators
      logic cnt_rst;   // restart the slot sweep counter
      logic clr_wr;    // write zero at the sweep address, advance
      logic rd_step;   // read the sweep address, advance
      logic span_ld;   // register window length in microseconds
      logic thr_ld;    // register the threshold time
      logic rsp_ld;    // move the totals into the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic cnt_last;  // sweep counter sits at the last slot
      logic pipe_busy; // scan compare/accumulate stages still hold data
      logic rsp_busy;  // result register full and not being taken
   } status_type;

endpackage

// ----- hw/rtl/shll_ifs.sv -----
// Valid/ready channel interfaces for the sketch request and response.
// Depends on shll_pkg for field widths.
interface shll_req_if;
   logic                             valid;
   logic                             ready;
   logic [shll_pkg::MODE_W-1:0]      mode;
   logic [shll_pkg::HASH_BITS-1:0]   hash_value;
   logic [shll_pkg::TIME_W-1:0]      now_usec;
   logic [shll_pkg::WIN_W-1:0]       window_seconds;
   logic                             whole_history;

   modport source (output valid, mode, hash_value, now_usec, window_seconds, whole_history,
                   input ready);
   modport sink   (input valid, mode, hash_value, now_usec, window_seconds, whole_history,
                   output ready);
endinterface

interface shll_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [shll_pkg::SUM_W-1:0]       harmonic_sum;
   logic [shll_pkg::EMPTY_W-1:0]     empty_registers;

   modport source (output valid, harmonic_sum, empty_registers, input ready);
   modport sink   (input valid, harmonic_sum, empty_registers, output ready);
endinterface

// ----- hw/rtl/shll_ctrl.sv -----
// Sequencer for the sketch: request acceptance, clear sweeps and estimate scans.
// Depends on shll_pkg for the command/status structs and operation codes.
module shll_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [shll_pkg::MODE_W-1:0] req_mode,
   output logic                        req_ready,
   input  shll_pkg::status_type        status,
   output shll_pkg::cmd_type           cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SPAN,
      S_THRESH,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  shll_pkg::MODE_ADD: begin
                     cmd.add_ld = 1'b1;
                  end
                  shll_pkg::MODE_ESTIMATE: begin
                     cmd.est_ld  = 1'b1;
                     cmd.cnt_rst = 1'b1;
                     state_in    = S_SPAN;
                  end
                  shll_pkg::MODE_CLEAR: begin
                     cmd.cnt_rst = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: begin
                     // unused code: transfer taken, nothing done
                  end
               endcase
            end
         end
         S_SPAN: begin
            cmd.span_ld = 1'b1;
            state_in    = S_THRESH;
         end
         S_THRESH: begin
            cmd.thr_ld = 1'b1;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            cmd.rd_step = 1'b1;
            if (status.cnt_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!status.rsp_busy) begin
               cmd.rsp_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered ready; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

endmodule

// ----- hw/rtl/shll_datapath.sv -----
// Datapath of the sketch: timestamp memory, add address path, scan compare,
// harmonic sum accumulation and the result register. Depends on shll_pkg.
module shll_datapath #(
   parameter int INDEX_BITS = shll_pkg::INDEX_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  shll_pkg::cmd_type              cmd,
   output shll_pkg::status_type           status,
   input  logic [shll_pkg::HASH_BITS-1:0] hash_value,
   input  logic [shll_pkg::TIME_W-1:0]    now_usec,
   input  logic [shll_pkg::WIN_W-1:0]     window_seconds,
   input  logic                           whole_history,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [shll_pkg::SUM_W-1:0]     harmonic_sum,
   output logic [shll_pkg::EMPTY_W-1:0]   empty_registers
);

   localparam int RANK_BITS = shll_pkg::HASH_BITS - INDEX_BITS;
   localparam int RANKS     = RANK_BITS + 1;
   localparam int NSLOTS    = (1 << INDEX_BITS) * RANKS;
   localparam int ADDR_W    = $clog2(NSLOTS);
   localparam int RW        = shll_pkg::RANK_W;
   localparam int TW        = shll_pkg::TIME_W;

   localparam logic [RW-1:0]     RANK_MAX  = RW'(RANKS);
   localparam logic [RW-1:0]     RANK_ONE  = RW'(1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(NSLOTS - 1);

   // Timestamp store, one word per register and rank
   logic [TW-1:0] mem [NSLOTS];

   // Add path registers
   logic                  add_vld_ff;
   logic [INDEX_BITS-1:0] add_reg_ff;
   logic [RW-1:0]         add_rank_ff;
   logic [TW-1:0]         add_time_ff;
   logic [RW-1:0]         rank_c;
   logic [ADDR_W-1:0]     add_addr;

   // Estimate operands
   logic [TW-1:0]                now_ff;
   logic [shll_pkg::WIN_W-1:0]   win_ff;
   logic                         whole_ff;
   logic [shll_pkg::SPAN_W-1:0]  span_ff;
   logic [TW-1:0]                thr_ff;
   logic [TW:0]                  diff;

   // Sweep counters
   logic [ADDR_W-1:0] cnt_ff;
   logic [RW-1:0]     k_ff;

   // Scan pipeline
   logic          b_vld_ff;
   logic [RW-1:0] b_k_ff;
   logic [TW-1:0] rd_data_ff;
   logic [RW-1:0] best_ff;
   logic [RW-1:0] cur_best;
   logic [RW-1:0] new_best;
   logic          c_vld_ff;
   logic [RW-1:0] c_best_ff;

   // Accumulators and result register
   logic [shll_pkg::SUM_W-1:0]   sum_ff;
   logic [shll_pkg::EMPTY_W-1:0] empty_ff;
   logic                         rsp_vld_ff;
   logic [shll_pkg::SUM_W-1:0]   rsp_sum_ff;
   logic [shll_pkg::EMPTY_W-1:0] rsp_empty_ff;

   // Memory write port
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [TW-1:0]     wr_data;

   // Rank: leading-one position below the index bits, max rank when all zero
   always_comb begin
      rank_c = RANK_MAX;
      for (int i = 0; i < RANK_BITS; i++) begin
         if (hash_value[i]) begin
            rank_c = RW'(RANK_BITS - i);
         end
      end
   end

   // Add capture; the memory write lands in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         add_vld_ff <= 1'b0;
      end else begin
         add_vld_ff <= cmd.add_ld;
      end
      if (cmd.add_ld) begin
         add_reg_ff  <= hash_value[shll_pkg::HASH_BITS-1:RANK_BITS];
         add_rank_ff <= rank_c;
         add_time_ff <= now_usec;
      end
   end

   assign add_addr = ADDR_W'(add_reg_ff) * ADDR_W'(RANKS)
                   + ADDR_W'(add_rank_ff) - ADDR_W'(1);

   // Write port: clear sweep or pending add, never both in one cycle
   assign wr_en   = cmd.clr_wr || add_vld_ff;
   assign wr_addr = cmd.clr_wr ? cnt_ff : add_addr;
   assign wr_data = cmd.clr_wr ? '0 : add_time_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_step) begin
         rd_data_ff <= mem[cnt_ff];
      end
   end

   // Sweep counter over slots, rank tag over each register's slots
   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_rst) begin
         cnt_ff <= '0;
         k_ff   <= RANK_ONE;
      end else if (cmd.clr_wr || cmd.rd_step) begin
         cnt_ff <= cnt_ff + ADDR_W'(1);
         k_ff   <= (k_ff == RANK_MAX) ? RANK_ONE : k_ff + RANK_ONE;
      end
   end

   // Estimate operands, window span and threshold
   assign diff = {1'b0, now_ff} - (TW + 1)'(span_ff);

   always_ff @(posedge clock) begin
      if (cmd.est_ld) begin
         now_ff   <= now_usec;
         win_ff   <= window_seconds;
         whole_ff <= whole_history;
      end
      if (cmd.span_ld) begin
         span_ff <= shll_pkg::SPAN_W'(win_ff) * shll_pkg::SPAN_W'(shll_pkg::USEC_PER_SEC);
      end
      if (cmd.thr_ld) begin
         if (!whole_ff && !diff[TW] && (diff[TW-1:0] > TW'(1))) begin
            thr_ff <= diff[TW-1:0];
         end else begin
            thr_ff <= TW'(1);
         end
      end
   end

   // Compare stage: highest rank seen at or after the threshold
   always_comb begin
      cur_best = (b_k_ff == RANK_ONE) ? '0 : best_ff;
      new_best = (rd_data_ff >= thr_ff) ? b_k_ff : cur_best;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= cmd.rd_step;
         c_vld_ff <= b_vld_ff && (b_k_ff == RANK_MAX);
      end
      if (cmd.rd_step) begin
         b_k_ff <= k_ff;
      end
      if (b_vld_ff) begin
         best_ff   <= new_best;
         c_best_ff <= new_best;
      end
   end

   // Accumulate 2^-R in fixed point and count empty registers
   always_ff @(posedge clock) begin
      if (cmd.est_ld) begin
         sum_ff   <= '0;
         empty_ff <= '0;
      end else if (c_vld_ff) begin
         sum_ff   <= sum_ff + (shll_pkg::SUM_W'(1) << (RANK_MAX - c_best_ff));
         empty_ff <= empty_ff + shll_pkg::EMPTY_W'(c_best_ff == '0);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.rsp_ld) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (cmd.rsp_ld) begin
         rsp_sum_ff   <= sum_ff;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign harmonic_sum    = rsp_sum_ff;
   assign empty_registers = rsp_empty_ff;

   assign status.cnt_last  = (cnt_ff == ADDR_LAST);
   assign status.pipe_busy = b_vld_ff || c_vld_ff;
   assign status.rsp_busy  = rsp_vld_ff && !rsp_ready;

endmodule

// ----- hw/rtl/sliding_hyperloglog_sketch.sv -----
// Sliding-window HyperLogLog sketch: last-seen timestamp store per register and rank.
// Top level; depends on shll_pkg, shll_ifs, shll_ctrl and shll_datapath.
//
// Usage: requests arrive on req_if (mode 0 add, 1 estimate, 2 clear; mode 3 is
// taken and ignored). Only an estimate produces a transfer on rsp_if, carrying
// the exact fixed-point sum of 2^-R over all registers and the empty count.
// Slots: NSLOTS = 2^INDEX_BITS * (33 - INDEX_BITS), 23552 at the default.
// Add: one transfer per cycle; the memory write lands the cycle after it.
// Estimate: span, then threshold registered; the scan reads one slot per cycle through
// the single read port of the timestamp memory, then drains into the result register.
// Clear: one slot written per cycle over all NSLOTS slots, no new request taken.
// Reset: synchronous; afterwards a clearing pass over all NSLOTS slots zeroes the
// store while req_if.ready stays low.
// Stall: the response sits in an output register; adds and clears keep being
// taken while it waits. A following estimate scans and then holds its totals
// until the previous response has been transferred.
module sliding_hyperloglog_sketch #(
   parameter int INDEX_BITS = shll_pkg::INDEX_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   shll_req_if.sink    req_if,
   shll_rsp_if.source  rsp_if
);

   shll_pkg::cmd_type    cmd;
   shll_pkg::status_type status;

   // Request sequencing
   shll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic
   shll_datapath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .hash_value      (req_if.hash_value),
      .now_usec        (req_if.now_usec),
      .window_seconds  (req_if.window_seconds),
      .whole_history   (req_if.whole_history),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .harmonic_sum    (rsp_if.harmonic_sum),
      .empty_registers (rsp_if.empty_registers)
   );

endmodule

// ----- dv/shll_estimate_checker.sv -----
// Scoreboard for the sliding-window HyperLogLog sketch: watches both channels,
// keeps its own timestamp store and compares every estimate response.
// Depends on shll_pkg and the channel interfaces in shll_ifs.
module shll_estimate_checker #(
   parameter int INDEX_BITS = shll_pkg::INDEX_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   shll_req_if         req_mon,
   shll_rsp_if         rsp_mon,
   output int unsigned n_fail,
   output int unsigned n_pending
);
   import shll_pkg::*;

   localparam int RANK_BITS = HASH_BITS - INDEX_BITS;
   localparam int RANKS     = RANK_BITS + 1;
   localparam int NREG      = 1 << INDEX_BITS;

   typedef struct packed {
      logic [SUM_W-1:0]   harmonic_sum;
      logic [EMPTY_W-1:0] empty_registers;
   } estimate_t;

   // last time each (register, rank) pair was seen; zero means never
   logic [TIME_W-1:0] last_seen [NREG][RANKS];
   estimate_t         expected_estimates [$];
   estimate_t         exp_est;
   int unsigned       mismatches = 0;

   // scratch for the add and estimate paths
   int unsigned       add_rank;
   int unsigned       reg_idx;
   int unsigned       best_rank;
   int unsigned       empty_acc;
   logic [63:0]       span_usec;
   logic [63:0]       threshold;
   logic [63:0]       sum_acc;

   function automatic void clear_store();
      for (int r = 0; r < NREG; r++) begin
         for (int k = 0; k < RANKS; k++) begin
            last_seen[r][k] = '0;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_store();
         expected_estimates.delete();
      end else begin
         // response side first: a response can never belong to a request taken this cycle
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_estimates.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected response: sum=%0h empty=%0d",
                           rsp_mon.harmonic_sum, rsp_mon.empty_registers);
               mismatches++;
            end else begin
               exp_est = expected_estimates.pop_front();
               if (rsp_mon.harmonic_sum !== exp_est.harmonic_sum ||
                   rsp_mon.empty_registers !== exp_est.empty_registers) begin
                  if (mismatches < 10)
                     $display("estimate mismatch: sum exp=%0h act=%0h, empty exp=%0d act=%0d",
                              exp_est.harmonic_sum, rsp_mon.harmonic_sum,
                              exp_est.empty_registers, rsp_mon.empty_registers);
                  mismatches++;
               end
            end
         end

         // request side: update the store or predict the estimate
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.mode)
               MODE_ADD: begin
                  // leading one of the rank bits, 1-based; all zero gives the top rank
                  add_rank = RANKS;
                  for (int i = 0; i < RANK_BITS; i++) begin
                     if (req_mon.hash_value[i])
                        add_rank = RANK_BITS - i;
                  end
                  reg_idx = req_mon.hash_value >> RANK_BITS;
                  last_seen[reg_idx][add_rank-1] = req_mon.now_usec;
               end
               MODE_ESTIMATE: begin
                  span_usec = 64'(req_mon.window_seconds) * 64'(USEC_PER_SEC);
                  threshold = 64'd1;
                  if (!req_mon.whole_history && 64'(req_mon.now_usec) > span_usec &&
                      64'(req_mon.now_usec) - span_usec > 64'd1)
                     threshold = 64'(req_mon.now_usec) - span_usec;
                  sum_acc   = '0;
                  empty_acc = 0;
                  for (int r = 0; r < NREG; r++) begin
                     best_rank = 0;
                     for (int k = 1; k <= RANKS; k++) begin
                        if (64'(last_seen[r][k-1]) >= threshold)
                           best_rank = k;
                     end
                     sum_acc += 64'd1 << (RANKS - best_rank);
                     if (best_rank == 0)
                        empty_acc++;
                  end
                  exp_est.harmonic_sum    = SUM_W'(sum_acc);
                  exp_est.empty_registers = EMPTY_W'(empty_acc);
                  expected_estimates.push_back(exp_est);
               end
               MODE_CLEAR: clear_store();
               default: ;
            endcase
         end
      end
      n_fail    <= mismatches;
      n_pending <= expected_estimates.size();
   end

endmodule

// ----- dv/sliding_hyperloglog_sketch_tb.sv -----
// Top of the sketch testbench: clock, reset, directed and random requests,
// response backpressure and the verdict. Depends on shll_pkg, shll_ifs, the
// sketch RTL and shll_estimate_checker.
module sliding_hyperloglog_sketch_tb;
   import shll_pkg::*;

   localparam int RANK_BITS     = HASH_BITS - INDEX_BITS_DEF;
   localparam int NSLOTS        = (1 << INDEX_BITS_DEF) * (RANK_BITS + 1);
   localparam int RANDOM_ITEMS  = 1100;
   localparam int unsigned CYCLE_LIMIT = 100_000_000;
   localparam logic [MODE_W-1:0]    MODE_IGNORED = 2'd3;
   localparam logic [TIME_W-1:0]    TIME_MAX     = '1;
   localparam logic [HASH_BITS-1:0] RANK_MASK    = (32'd1 << RANK_BITS) - 32'd1;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned n_fail;
   int unsigned n_pending;
   int unsigned cycle_count = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned n_items;
   int unsigned roll;
   int unsigned phase;
   bit          paused;
   logic [TIME_W-1:0]    time_base;
   logic [TIME_W-1:0]    stamp;
   logic [HASH_BITS-1:0] hash_word;
   logic [WIN_W-1:0]     win_sec;

   shll_req_if req_if ();
   shll_rsp_if rsp_if ();

   sliding_hyperloglog_sketch u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   shll_estimate_checker u_check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .n_fail    (n_fail),
      .n_pending (n_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response backpressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic put_req(input logic [MODE_W-1:0] mode, input logic [HASH_BITS-1:0] hash,
                          input logic [TIME_W-1:0] now, input logic [WIN_W-1:0] win,
                          input logic whole);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.mode           <= mode;
      req_if.hash_value     <= hash;
      req_if.now_usec       <= now;
      req_if.window_seconds <= win;
      req_if.whole_history  <= whole;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // hold off until every predicted estimate has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (n_pending != 0);
   endtask

   initial begin
      req_if.valid          <= 1'b0;
      req_if.mode           <= MODE_ADD;
      req_if.hash_value     <= '0;
      req_if.now_usec       <= '0;
      req_if.window_seconds <= '0;
      req_if.whole_history  <= 1'b0;
      reset                 <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, rank and register extremes, threshold corners
      put_req(MODE_ESTIMATE, $urandom, '0, '0, 1'b1);
      put_req(MODE_ADD, 32'h0000_0000, TIME_W'(5), $urandom, 1'b0);  // all-zero rank bits
      put_req(MODE_ADD, 32'hFFFF_FFFF, TIME_MAX, $urandom, 1'b1);    // last register, rank 1
      put_req(MODE_ADD, 32'h0020_0000, TIME_W'(3), $urandom, 1'b0);  // register 0, rank 1
      put_req(MODE_ADD, 32'h0140_0001, '0, $urandom, 1'b1);          // add at time zero
      put_req(MODE_ADD, 32'h0080_0000, TIME_W'(1), $urandom, 1'b0);  // written at time one
      put_req(MODE_ADD, 32'hFFC0_0001, TIME_W'(100), $urandom, 1'b0);
      put_req(MODE_ESTIMATE, $urandom, '0, '0, 1'b1);
      put_req(MODE_ESTIMATE, $urandom, TIME_W'(1_000_001), WIN_W'(1), 1'b0); // threshold one
      put_req(MODE_ESTIMATE, $urandom, TIME_W'(1_000_002), WIN_W'(1), 1'b0); // threshold two
      put_req(MODE_ESTIMATE, $urandom, TIME_W'(12345), 32'hFFFF_FFFF, 1'b0); // before time one
      put_req(MODE_ESTIMATE, $urandom, TIME_MAX, '0, 1'b0);          // zero window
      put_req(MODE_ESTIMATE, $urandom, TIME_MAX, 32'hFFFF_FFFF, 1'b0);
      put_req(MODE_ESTIMATE, $urandom, TIME_W'(4), '0, 1'b0);
      put_req(MODE_IGNORED, '1, TIME_MAX, '1, 1'b1);
      put_req(MODE_ESTIMATE, '1, TIME_MAX, '1, 1'b1);
      put_req(MODE_CLEAR, $urandom, TIME_MAX, $urandom, 1'b1);
      put_req(MODE_ESTIMATE, $urandom, '0, '0, 1'b1);
      put_req(MODE_ADD, 32'h0020_0000, TIME_W'(7), $urandom, 1'b0);
      put_req(MODE_ESTIMATE, $urandom, TIME_W'(7), '0, 1'b0);

      // random: mostly adds on a rising time base, rare estimates and clears
      n_items   = 0;
      paused    = 1'b0;
      time_base = TIME_W'(1_000_000);
      while (n_items < RANDOM_ITEMS) begin
         phase = (n_items * 4) / RANDOM_ITEMS;
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 73; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 8;  stall_pct = 8;  end
         endcase
         if (!paused && n_items == RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end

         roll = $urandom_range(0, 999);
         if (roll < 3) begin
            put_req(MODE_CLEAR, $urandom, TIME_W'({$urandom, $urandom}), $urandom,
                    1'($urandom_range(0, 1)));
            n_items++;
         end else if (roll < 31) begin
            stamp   = ($urandom_range(0, 9) == 0) ? TIME_W'({$urandom, $urandom}) : time_base;
            win_sec = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120);
            put_req(MODE_ESTIMATE, $urandom, stamp, win_sec, $urandom_range(0, 3) == 0);
            n_items++;
         end else if (roll < 51) begin
            // ignored mode, noise only
            put_req(MODE_IGNORED, $urandom, TIME_W'({$urandom, $urandom}), $urandom,
                    1'($urandom_range(0, 1)));
         end else begin
            time_base += TIME_W'($urandom_range(0, 500_000));
            if ($urandom_range(0, 99) == 0)
               time_base = TIME_W'({$urandom, $urandom});
            stamp = ($urandom_range(0, 19) == 0) ? TIME_W'({$urandom, $urandom}) : time_base;
            // a hot set of registers collects many ranks; rank bits get a random depth
            if ($urandom_range(0, 3) == 0)
               hash_word = $urandom;
            else
               hash_word = (HASH_BITS'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                            : $urandom_range(0, 1023))
                            << RANK_BITS) |
                           ((HASH_BITS'($urandom) & RANK_MASK) >> $urandom_range(0, RANK_BITS));
            put_req(MODE_ADD, hash_word, stamp, $urandom, 1'($urandom_range(0, 1)));
            n_items++;
         end
      end

      // drain, then watch for stray responses before the verdict
      wait_drained();
      repeat (NSLOTS + 16) @(posedge clock);
      if (n_fail == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
